// ===== rtl/bpps_pkg.sv =====
package bpps_pkg;

   localparam int NEIGHBORS_DEFAULT = 24;

   // configuration register indexes
   localparam logic [2:0] CSR_RSSI_THRESHOLD  = 3'd0;
   localparam logic [2:0] CSR_PARENT_TIMEOUT  = 3'd1;
   localparam logic [2:0] CSR_PARENT_DWELL    = 3'd2;
   localparam logic [2:0] CSR_PRR_HYSTERESIS  = 3'd3;
   localparam logic [2:0] CSR_PRR_ABS_MIN     = 3'd4;
   localparam logic [2:0] CSR_PRR_IMPROVE_MIN = 3'd5;
   localparam logic [2:0] CSR_NODE_IS_ROOT    = 3'd6;

   localparam int CSR_DATA_W = 32;

   // reset values
   localparam logic signed [7:0] RSSI_THRESHOLD_RST = -8'sd95;
   localparam logic [31:0] PARENT_TIMEOUT_RST = 32'd7680;
   localparam logic [31:0] PARENT_DWELL_RST   = 32'd3840;
   localparam logic [6:0]  PRR_HYSTERESIS_RST = 7'd25;
   localparam logic [6:0]  PRR_ABS_MIN_RST    = 7'd80;
   localparam logic [6:0]  PRR_IMPROVE_MIN_RST = 7'd60;
   localparam logic [15:0] METRIC_NONE = 16'hFFFF;
   localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

   // one neighbour table row
   typedef struct packed {
      logic [15:0] addr;
      logic [15:0] last_seq;
      logic [31:0] expected;
      logic [31:0] received;
      logic [31:0] heard_at;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ===== rtl/beacon_prr_parent_selector.sv =====
// beacon parent selector with per-neighbour reception rate
//
// req_ channel: one received beacon per transaction (valid/ready). rsp_
// channel: one result per beacon, held in an output register until taken.
// csr_ port: plain write, index per register list, no read-back; write only
// while the block is idle. Writing node_is_root also reloads the own metric.
//
// Sequence: a sequencer around a one-port-read table memory walks all
// NEIGHBORS rows once for the sender, the parent and the eviction victim,
// writes the updated row, then runs two serial divisions for the sender
// and parent rates with a parent row read between. Beacons dropped for low
// RSSI skip the table and go straight to the output register.
// One beacon is handled at a time; req_ready is low while one is in flight
// or while an undelivered result still sits in the output register.
//
// Reset clears the valid bits of the table, parent state, metric and epoch,
// and loads register defaults. No clearing pass is needed. A stalled
// receiver just holds the result; no further beacon is taken.
module beacon_prr_parent_selector #(
   parameter int NEIGHBORS = bpps_pkg::NEIGHBORS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_sender_addr,
   input  logic [15:0] req_beacon_epoch,
   input  logic [15:0] req_beacon_tx_seq,
   input  logic [15:0] req_sender_hops,
   input  logic signed [7:0] req_rssi,
   input  logic [31:0] req_now_ticks,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_rssi_dropped,
   output logic        rsp_forward_beacon,
   output logic        rsp_topology_hold,
   output logic        rsp_parent_changed,
   output logic        rsp_parent_valid,
   output logic [15:0] rsp_parent_addr,
   output logic [15:0] rsp_own_metric,
   output logic [15:0] rsp_own_epoch,
   output logic [6:0]  rsp_sender_prr,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [bpps_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int IW = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
   localparam int CW = $clog2(NEIGHBORS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_WRITE, S_DIV_S, S_WAIT_S, S_PREAD, S_PWAIT, S_DIV_P,
      S_WAIT_P, S_DECIDE, S_OUT
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic signed [7:0] rssi_thr_ff;
   logic [31:0] timeout_ff, dwell_ff;
   logic [6:0]  hyst_ff, absmin_ff, impmin_ff;

   // node state
   logic        present_ff;
   logic [15:0] link_ff, metric_ff, epoch_ff;
   logic [31:0] lock_ff;

   // captured beacon
   logic [15:0] snd_ff, bep_ff, seq_ff, hops_ff;
   logic [31:0] now_ff;

   logic [NEIGHBORS-1:0] used_ff;
   logic [CW-1:0] cnt_ff;
   logic [IW-1:0] sidx_ff, pidx_ff, vidx_ff;
   logic          sfound_ff, pfound_ff, vfree_ff;
   logic [31:0]   vmin_ff;
   bpps_pkg::entry_type srow_ff, prow_ff;
   logic [6:0]    sprr_ff, pprr_ff;

   // memory
   logic          ram_we;
   logic [IW-1:0] ram_waddr, ram_raddr;
   bpps_pkg::entry_type ram_wdata, ram_rdata;
   logic [bpps_pkg::ENTRY_W-1:0] ram_rbits;

   bpps_ram #(.WIDTH(bpps_pkg::ENTRY_W), .DEPTH(NEIGHBORS)) u_table (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rbits)
   );
   assign ram_rdata = bpps_pkg::entry_type'(ram_rbits);

   // divider
   logic        div_start, div_done;
   logic [31:0] div_rcv, div_exp;
   logic [6:0]  div_prr;

   bpps_prr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .received(div_rcv),
      .expected(div_exp),
      .done    (div_done),
      .prr     (div_prr)
   );

   // output register
   logic        o_valid_ff, o_drop_ff, o_fwd_ff, o_hold_ff, o_chg_ff;

   // scan row address: the row read last cycle is cnt_ff-1
   logic [IW-1:0] rd_row;
   assign rd_row = IW'(cnt_ff - CW'(1));

   // updated sender row
   bpps_pkg::entry_type upd;
   logic [15:0] gap16;
   logic [31:0] gap;
   always_comb begin
      upd = srow_ff;
      gap16 = seq_ff - srow_ff.last_seq;
      gap = (gap16 == 16'd0) ? 32'd1 : {16'd0, gap16};
      if (srow_ff.expected == 32'd0 && srow_ff.received == 32'd0) begin
         upd.expected = 32'd1;
         upd.received = 32'd1;
      end else begin
         upd.expected = (srow_ff.expected > bpps_pkg::CNT_MAX - gap) ?
                        bpps_pkg::CNT_MAX : srow_ff.expected + gap;
         if (srow_ff.received != bpps_pkg::CNT_MAX) begin
            upd.received = srow_ff.received + 32'd1;
         end
      end
      upd.addr = snd_ff;
      upd.last_seq = seq_ff;
      upd.heard_at = now_ff;
   end

   assign ram_we    = (state_ff == S_WRITE);
   assign ram_waddr = sidx_ff;
   assign ram_wdata = upd;
   assign ram_raddr = (state_ff == S_SCAN) ? IW'(cnt_ff) :
                      (state_ff == S_PREAD) ? pidx_ff : sidx_ff;

   assign div_start = (state_ff == S_DIV_S) || (state_ff == S_DIV_P);
   assign div_rcv   = (state_ff == S_DIV_S) ? srow_ff.received : prow_ff.received;
   assign div_exp   = (state_ff == S_DIV_S) ? srow_ff.expected : prow_ff.expected;

   // decision
   logic [15:0] nm;
   logic        stale, p_in;
   logic        n_present;
   logic [15:0] n_link, n_metric, n_epoch;
   logic [31:0] n_lock;
   logic        n_fwd, n_hold, adopt;
   logic [7:0]  pthr;
   always_comb begin
      nm = (hops_ff == 16'hFFFF) ? 16'hFFFF : hops_ff + 16'd1;
      p_in = present_ff && pfound_ff;
      stale = p_in && ((now_ff - prow_ff.heard_at) > timeout_ff);
      pthr = {1'b0, (p_in ? pprr_ff : 7'd0)} + {1'b0, hyst_ff};
      n_metric = metric_ff;
      n_epoch = epoch_ff;
      n_fwd = 1'b0;
      n_hold = 1'b0;
      adopt = 1'b0;
      if (epoch_ff < bep_ff) begin
         n_epoch = bep_ff;
         n_metric = nm;
         n_fwd = 1'b1;
         if (!present_ff) begin
            adopt = 1'b1;
            n_hold = 1'b1;
         end else if (nm < metric_ff) begin
            if (!(sprr_ff < impmin_ff && !stale) && link_ff != snd_ff) begin
               adopt = 1'b1;
               n_hold = 1'b1;
            end
         end else if (stale && link_ff != snd_ff) begin
            adopt = 1'b1;
            n_hold = 1'b1;
         end
      end else if (nm < metric_ff) begin
         if (!(sprr_ff < impmin_ff && present_ff && !stale)) begin
            n_metric = nm;
            adopt = !present_ff || link_ff != snd_ff;
         end
         n_hold = 1'b1;
         n_fwd = 1'b1;
      end else if (nm == metric_ff) begin
         if (present_ff && now_ff < lock_ff && !stale) begin
            adopt = 1'b0;
         end else if (sprr_ff < absmin_ff) begin
            adopt = 1'b0;
         end else if (!present_ff || {1'b0, sprr_ff} >= pthr) begin
            adopt = !present_ff || link_ff != snd_ff;
         end
         n_hold = 1'b1;
         n_fwd = 1'b1;
      end
      n_present = present_ff | adopt;
      n_link = adopt ? snd_ff : link_ff;
      n_lock = adopt ? now_ff + dwell_ff : lock_ff;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = (req_rssi < rssi_thr_ff) ? S_OUT : S_SCAN;
            end
         end
         S_SCAN:   state_in = (cnt_ff == CW'(NEIGHBORS)) ? S_WRITE : S_SCAN;
         S_WRITE:  state_in = S_DIV_S;
         S_DIV_S:  state_in = S_WAIT_S;
         S_WAIT_S: state_in = div_done ? S_PREAD : S_WAIT_S;
         S_PREAD:  state_in = S_PWAIT;
         S_PWAIT:  state_in = S_DIV_P;
         S_DIV_P:  state_in = S_WAIT_P;
         S_WAIT_P: state_in = div_done ? S_DECIDE : S_WAIT_P;
         S_DECIDE: state_in = S_OUT;
         S_OUT:    state_in = (o_valid_ff && rsp_ready) ? S_IDLE : S_OUT;
         default:  state_in = S_IDLE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

   logic row_hit_s, row_hit_p;
   assign row_hit_s = used_ff[rd_row] && ram_rdata.addr == snd_ff;
   assign row_hit_p = used_ff[rd_row] && ram_rdata.addr == link_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         rssi_thr_ff <= bpps_pkg::RSSI_THRESHOLD_RST;
         timeout_ff  <= bpps_pkg::PARENT_TIMEOUT_RST;
         dwell_ff    <= bpps_pkg::PARENT_DWELL_RST;
         hyst_ff     <= bpps_pkg::PRR_HYSTERESIS_RST;
         absmin_ff   <= bpps_pkg::PRR_ABS_MIN_RST;
         impmin_ff   <= bpps_pkg::PRR_IMPROVE_MIN_RST;
         present_ff  <= 1'b0;
         link_ff     <= '0;
         metric_ff   <= bpps_pkg::METRIC_NONE;
         epoch_ff    <= '0;
         lock_ff     <= '0;
         used_ff     <= '0;
         o_valid_ff  <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         state_ff <= state_in;
         // configuration writes
         if (csr_write) begin
            case (csr_index)
               bpps_pkg::CSR_RSSI_THRESHOLD:  rssi_thr_ff <= csr_wdata[7:0];
               bpps_pkg::CSR_PARENT_TIMEOUT:  timeout_ff  <= csr_wdata;
               bpps_pkg::CSR_PARENT_DWELL:    dwell_ff    <= csr_wdata;
               bpps_pkg::CSR_PRR_HYSTERESIS:  hyst_ff     <= csr_wdata[6:0];
               bpps_pkg::CSR_PRR_ABS_MIN:     absmin_ff   <= csr_wdata[6:0];
               bpps_pkg::CSR_PRR_IMPROVE_MIN: impmin_ff   <= csr_wdata[6:0];
               bpps_pkg::CSR_NODE_IS_ROOT: begin
                  metric_ff <= csr_wdata[0] ? 16'd0 : bpps_pkg::METRIC_NONE;
               end
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               cnt_ff <= '0;
               if (req_valid && req_rssi < rssi_thr_ff) begin
                  o_valid_ff <= 1'b1;
               end
            end
            S_SCAN: begin
               cnt_ff <= cnt_ff + CW'(1);
               if (cnt_ff != '0) begin
                  if (row_hit_s && !sfound_ff) begin
                     sfound_ff <= 1'b1;
                     sidx_ff   <= rd_row;
                     srow_ff   <= ram_rdata;
                  end
                  if (row_hit_p && !pfound_ff) begin
                     pfound_ff <= 1'b1;
                     pidx_ff   <= rd_row;
                  end
                  if (!vfree_ff) begin
                     if (!used_ff[rd_row]) begin
                        vfree_ff <= 1'b1;
                        vidx_ff  <= rd_row;
                     end else if (cnt_ff == CW'(1) || ram_rdata.expected < vmin_ff) begin
                        vidx_ff <= rd_row;
                        vmin_ff <= ram_rdata.expected;
                     end
                  end
               end
            end
            S_WRITE: begin
               // allocate when sender is new: fresh zero row at the victim
               used_ff[sidx_ff] <= 1'b1;
               srow_ff <= upd;
               // parent row follows the sender row once it is written
               if (link_ff == snd_ff) begin
                  pfound_ff <= 1'b1;
                  pidx_ff   <= sidx_ff;
               end else if (pfound_ff && pidx_ff == sidx_ff) begin
                  pfound_ff <= 1'b0;
               end
            end
            S_WAIT_S: begin
               if (div_done) sprr_ff <= div_prr;
            end
            S_PWAIT: prow_ff <= ram_rdata;
            S_WAIT_P: begin
               if (div_done) pprr_ff <= div_prr;
            end
            S_DECIDE: begin
               present_ff <= n_present;
               link_ff    <= n_link;
               metric_ff  <= n_metric;
               epoch_ff   <= n_epoch;
               lock_ff    <= n_lock;
               o_valid_ff <= 1'b1;
            end
            S_OUT: begin
               if (o_valid_ff && rsp_ready) o_valid_ff <= 1'b0;
            end
            default: ;
         endcase
      end
      // payload registers
      case (state_ff)
         S_IDLE: begin
            snd_ff  <= req_sender_addr;
            bep_ff  <= req_beacon_epoch;
            seq_ff  <= req_beacon_tx_seq;
            hops_ff <= req_sender_hops;
            now_ff  <= req_now_ticks;
            sfound_ff <= 1'b0;
            pfound_ff <= 1'b0;
            vfree_ff  <= 1'b0;
            vmin_ff   <= '0;
            vidx_ff   <= '0;
            o_drop_ff <= 1'b1;
            o_fwd_ff  <= 1'b0;
            o_hold_ff <= 1'b0;
            o_chg_ff  <= 1'b0;
            sprr_ff   <= '0;
         end
         S_SCAN: begin
            if (cnt_ff == CW'(NEIGHBORS) && !sfound_ff && !row_hit_s) begin
               // new sender: victim row, zeroed
               sidx_ff <= (!vfree_ff && used_ff[rd_row] &&
                           ram_rdata.expected < vmin_ff) ? rd_row :
                          (!vfree_ff && !used_ff[rd_row]) ? rd_row : vidx_ff;
               srow_ff <= '0;
            end
         end
         S_DECIDE: begin
            o_drop_ff <= 1'b0;
            o_fwd_ff  <= n_fwd;
            o_hold_ff <= n_hold;
            o_chg_ff  <= (present_ff != n_present) || (n_present && link_ff != n_link);
         end
         default: ;
      endcase
   end

   assign rsp_valid          = o_valid_ff;
   assign rsp_rssi_dropped   = o_drop_ff;
   assign rsp_forward_beacon = o_fwd_ff;
   assign rsp_topology_hold  = o_hold_ff;
   assign rsp_parent_changed = o_chg_ff;
   assign rsp_parent_valid   = present_ff;
   assign rsp_parent_addr    = present_ff ? link_ff : 16'd0;
   assign rsp_own_metric     = metric_ff;
   assign rsp_own_epoch      = epoch_ff;
   assign rsp_sender_prr     = sprr_ff;

endmodule

// ===== rtl/bpps_ram.sv =====
module bpps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bpps_prr_div.sv =====
// restoring divider: percent = min(100, received*100 / expected), one bit a cycle
module bpps_prr_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] received,
   input  logic [31:0] expected,
   output logic        done,
   output logic [6:0]  prr
);

   logic [38:0] num_ff, num_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [38:0] quo_ff, quo_in;
   logic [33:0] trial;
   logic [38:0] prod;

   // received * 100 as a 39-bit product
   assign prod = {7'd0, received} * 39'd100;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      quo_in  = quo_ff;
      done_in = 1'b0;
      trial   = '0;
      if (start) begin
         num_in  = prod;
         rem_in  = '0;
         den_in  = expected;
         cnt_in  = 6'd39;
         quo_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial  = {rem_ff, num_ff[38]} - {2'b00, den_ff};
         num_in = {num_ff[37:0], 1'b0};
         if (!trial[33]) begin
            rem_in = trial[32:0];
            quo_in = {quo_ff[37:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], num_ff[38]};
            quo_in = {quo_ff[37:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign prr  = (den_ff == 32'd0) ? 7'd0 :
                 (quo_ff > 39'd100) ? 7'd100 : quo_ff[6:0];

endmodule
